>>> hdl/sllm_pkg.sv
// Package for the static linked list manager: request and result beat types,
// action, status and sequencer state codes, fixed field widths.
// Depends on nothing; the files that use it take its names by scoped reference.
`timescale 1ns / 1ps

package sllm_pkg;

	localparam int unsigned HANDLE_W = 6;
	localparam int unsigned POS_W    = 6;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned COUNT_W  = 6;

	typedef enum logic [2:0] {
		ACT_CREATE  = 3'd0,
		ACT_CLEAR   = 3'd1,
		ACT_DESTROY = 3'd2,
		ACT_INSERT  = 3'd3,
		ACT_DELETE  = 3'd4,
		ACT_GET     = 3'd5,
		ACT_LOCATE  = 3'd6,
		ACT_LENGTH  = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ERR  = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_DISPATCH,
		S_CR_UPD,
		S_CL_HEAD,
		S_CL_CHK,
		S_CL_LINK,
		S_CL_GIVE,
		S_DS_GIVE,
		S_GT_HEAD,
		S_WK_CHK,
		S_WK_STEP,
		S_WK_END,
		S_IN_TAKE,
		S_IN_LINK,
		S_IN_HOOK,
		S_DL_NEXT,
		S_DL_UNLK,
		S_DL_GIVE,
		S_GT_DATA,
		S_SC_HEAD,
		S_SC_CHK,
		S_SC_STEP,
		S_FINISH
	} state_t;

	typedef struct packed {
		action_t              action;
		logic [HANDLE_W-1:0]  list_handle;
		logic [POS_W-1:0]     position;
		logic [VALUE_W-1:0]   item_value;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [VALUE_W-1:0]   result_value;
		logic [COUNT_W-1:0]   result_count;
		logic [HANDLE_W-1:0]  new_handle;
	} res_t;

endpackage

>>> hdl/sllm_mem.sv
// Simple dual-port memory: one write port, one read port, registered read data.
// Used for both the link store and the data store; depends on nothing.
`timescale 1ns / 1ps

module sllm_mem #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read-first: a same-cycle write is seen on the next read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/sllm_seq.sv
// Sequencer of the linked list manager: walks chains through the link and
// data stores one link at a time and keeps the free chain head in a register.
// Depends on sllm_pkg; drives the ports of two sllm_mem instances.
`timescale 1ns / 1ps

module sllm_seq #(
	parameter int unsigned POOL_NODES = 64,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  sllm_pkg::req_t                req,
	output logic                          idle,
	output logic                          done,
	input  logic                          taken,
	output sllm_pkg::res_t                res,
	output logic                          lnk_we,
	output logic [$clog2(POOL_NODES)-1:0] lnk_waddr,
	output logic [$clog2(POOL_NODES)-1:0] lnk_wdata,
	output logic [$clog2(POOL_NODES)-1:0] lnk_raddr,
	input  logic [$clog2(POOL_NODES)-1:0] lnk_rdata,
	output logic                          dat_we,
	output logic [$clog2(POOL_NODES)-1:0] dat_waddr,
	output logic [DATA_WIDTH-1:0]         dat_wdata,
	output logic [$clog2(POOL_NODES)-1:0] dat_raddr,
	input  logic [DATA_WIDTH-1:0]         dat_rdata
);

	localparam int unsigned AW = $clog2(POOL_NODES);
	localparam int unsigned GW = $clog2(POOL_NODES + 1);

	sllm_pkg::state_t  state_q, state_d;
	sllm_pkg::action_t act_q, act_d;
	sllm_pkg::status_t status_q, status_d;

	logic [sllm_pkg::HANDLE_W-1:0] hraw_q, hraw_d;
	logic [sllm_pkg::POS_W-1:0]    pos_q, pos_d;
	logic [sllm_pkg::POS_W-1:0]    cnt_q, cnt_d;
	logic [sllm_pkg::COUNT_W-1:0]  rcount_q, rcount_d;
	logic [DATA_WIDTH-1:0]         val_q, val_d;
	logic [DATA_WIDTH-1:0]         rval_q, rval_d;
	logic [AW-1:0]                 p_q, p_d;
	logic [AW-1:0]                 q_q, q_d;
	logic [AW-1:0]                 fh_q, fh_d;
	logic [AW-1:0]                 newh_q, newh_d;
	logic [AW-1:0]                 init_q, init_d;
	logic [GW-1:0]                 guard_q, guard_d;

	logic [AW-1:0] h_node;
	logic          h_ok;
	logic          guard_live;
	logic [GW-1:0] guard_inc;

	assign h_node     = AW'(hraw_q);
	assign h_ok       = (hraw_q != '0) && (32'(hraw_q) < POOL_NODES);
	assign guard_live = guard_q < GW'(POOL_NODES);
	assign guard_inc  = guard_q + GW'(1);

	assign idle = (state_q == sllm_pkg::S_IDLE);
	assign done = (state_q == sllm_pkg::S_FINISH);

	always_comb begin
		res.status       = status_q;
		res.result_value = sllm_pkg::VALUE_W'(rval_q);
		res.result_count = rcount_q;
		res.new_handle   = sllm_pkg::HANDLE_W'(newh_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sllm_pkg::S_INIT;
			init_q  <= '0;
			fh_q    <= AW'(1);
		end else begin
			state_q <= state_d;
			init_q  <= init_d;
			fh_q    <= fh_d;
		end
	end

	always_ff @(posedge clk) begin
		act_q    <= act_d;
		status_q <= status_d;
		hraw_q   <= hraw_d;
		pos_q    <= pos_d;
		cnt_q    <= cnt_d;
		rcount_q <= rcount_d;
		val_q    <= val_d;
		rval_q   <= rval_d;
		p_q      <= p_d;
		q_q      <= q_d;
		newh_q   <= newh_d;
		guard_q  <= guard_d;
	end

	always_comb begin
		state_d   = state_q;
		act_d     = act_q;
		status_d  = status_q;
		hraw_d    = hraw_q;
		pos_d     = pos_q;
		cnt_d     = cnt_q;
		rcount_d  = rcount_q;
		val_d     = val_q;
		rval_d    = rval_q;
		p_d       = p_q;
		q_d       = q_q;
		fh_d      = fh_q;
		newh_d    = newh_q;
		init_d    = init_q;
		guard_d   = guard_q;
		lnk_we    = 1'b0;
		lnk_waddr = '0;
		lnk_wdata = '0;
		lnk_raddr = '0;
		dat_we    = 1'b0;
		dat_waddr = '0;
		dat_wdata = '0;
		dat_raddr = '0;

		unique case (state_q)
			sllm_pkg::S_INIT: begin
				// lay down the free chain in index order, last node ends it
				lnk_we    = 1'b1;
				lnk_waddr = init_q;
				if (init_q == AW'(POOL_NODES - 1)) begin
					lnk_wdata = '0;
					state_d   = sllm_pkg::S_IDLE;
				end else begin
					lnk_wdata = init_q + AW'(1);
				end
				init_d = init_q + AW'(1);
			end
			sllm_pkg::S_IDLE: begin
				if (start) begin
					act_d    = req.action;
					hraw_d   = req.list_handle;
					pos_d    = req.position;
					val_d    = DATA_WIDTH'(req.item_value);
					status_d = sllm_pkg::ST_ERR;
					rval_d   = '0;
					rcount_d = '0;
					newh_d   = '0;
					guard_d  = '0;
					state_d  = sllm_pkg::S_DISPATCH;
				end
			end
			sllm_pkg::S_DISPATCH: begin
				unique case (act_q)
					sllm_pkg::ACT_CREATE: begin
						if (fh_q == '0) begin
							status_d = sllm_pkg::ST_FULL;
							state_d  = sllm_pkg::S_FINISH;
						end else begin
							p_d       = fh_q;
							lnk_raddr = fh_q;
							state_d   = sllm_pkg::S_CR_UPD;
						end
					end
					sllm_pkg::ACT_CLEAR, sllm_pkg::ACT_DESTROY: begin
						lnk_raddr = h_node;
						state_d   = h_ok ? sllm_pkg::S_CL_HEAD : sllm_pkg::S_FINISH;
					end
					sllm_pkg::ACT_INSERT, sllm_pkg::ACT_DELETE: begin
						p_d     = h_node;
						cnt_d   = sllm_pkg::POS_W'(1);
						state_d = (h_ok && pos_q != '0) ? sllm_pkg::S_WK_CHK
							: sllm_pkg::S_FINISH;
					end
					sllm_pkg::ACT_GET: begin
						lnk_raddr = h_node;
						state_d   = (h_ok && pos_q != '0 && 32'(pos_q) <= POOL_NODES - 2)
							? sllm_pkg::S_GT_HEAD : sllm_pkg::S_FINISH;
					end
					sllm_pkg::ACT_LOCATE, sllm_pkg::ACT_LENGTH: begin
						lnk_raddr = h_node;
						state_d   = h_ok ? sllm_pkg::S_SC_HEAD : sllm_pkg::S_FINISH;
					end
				endcase
			end
			sllm_pkg::S_CR_UPD: begin
				fh_d      = lnk_rdata;
				lnk_we    = 1'b1;
				lnk_waddr = p_q;
				lnk_wdata = '0;
				newh_d    = p_q;
				status_d  = sllm_pkg::ST_OK;
				state_d   = sllm_pkg::S_FINISH;
			end
			sllm_pkg::S_CL_HEAD: begin
				p_d     = lnk_rdata;
				state_d = sllm_pkg::S_CL_CHK;
			end
			sllm_pkg::S_CL_CHK: begin
				if (p_q != '0 && guard_live) begin
					lnk_raddr = p_q;
					state_d   = sllm_pkg::S_CL_LINK;
				end else if (act_q == sllm_pkg::ACT_DESTROY) begin
					state_d = sllm_pkg::S_DS_GIVE;
				end else begin
					status_d = sllm_pkg::ST_OK;
					state_d  = sllm_pkg::S_FINISH;
				end
			end
			sllm_pkg::S_CL_LINK: begin
				// unhook the first element from the head
				q_d       = lnk_rdata;
				lnk_we    = 1'b1;
				lnk_waddr = h_node;
				lnk_wdata = lnk_rdata;
				state_d   = sllm_pkg::S_CL_GIVE;
			end
			sllm_pkg::S_CL_GIVE: begin
				lnk_we    = 1'b1;
				lnk_waddr = p_q;
				lnk_wdata = fh_q;
				fh_d      = p_q;
				// a head that links to itself was just overwritten by the free link
				p_d       = (p_q == h_node) ? fh_q : q_q;
				guard_d   = guard_inc;
				state_d   = sllm_pkg::S_CL_CHK;
			end
			sllm_pkg::S_DS_GIVE: begin
				lnk_we    = 1'b1;
				lnk_waddr = h_node;
				lnk_wdata = fh_q;
				fh_d      = h_node;
				status_d  = sllm_pkg::ST_OK;
				state_d   = sllm_pkg::S_FINISH;
			end
			sllm_pkg::S_GT_HEAD: begin
				p_d     = lnk_rdata;
				cnt_d   = sllm_pkg::POS_W'(1);
				state_d = sllm_pkg::S_WK_CHK;
			end
			sllm_pkg::S_WK_CHK: begin
				if (p_q != '0 && cnt_q < pos_q) begin
					lnk_raddr = p_q;
					state_d   = sllm_pkg::S_WK_STEP;
				end else begin
					state_d = sllm_pkg::S_WK_END;
				end
			end
			sllm_pkg::S_WK_STEP: begin
				p_d     = lnk_rdata;
				cnt_d   = cnt_q + sllm_pkg::POS_W'(1);
				state_d = sllm_pkg::S_WK_CHK;
			end
			sllm_pkg::S_WK_END: begin
				if (p_q == '0) begin
					state_d = sllm_pkg::S_FINISH;
				end else begin
					case (act_q)
						sllm_pkg::ACT_INSERT: begin
							if (fh_q == '0) begin
								status_d = sllm_pkg::ST_FULL;
								state_d  = sllm_pkg::S_FINISH;
							end else begin
								q_d       = fh_q;
								lnk_raddr = fh_q;
								dat_we    = 1'b1;
								dat_waddr = fh_q;
								dat_wdata = val_q;
								state_d   = sllm_pkg::S_IN_TAKE;
							end
						end
						sllm_pkg::ACT_DELETE: begin
							lnk_raddr = p_q;
							state_d   = sllm_pkg::S_DL_NEXT;
						end
						default: begin
							dat_raddr = p_q;
							state_d   = sllm_pkg::S_GT_DATA;
						end
					endcase
				end
			end
			sllm_pkg::S_IN_TAKE: begin
				fh_d      = lnk_rdata;
				lnk_raddr = p_q;
				state_d   = sllm_pkg::S_IN_LINK;
			end
			sllm_pkg::S_IN_LINK: begin
				lnk_we    = 1'b1;
				lnk_waddr = q_q;
				lnk_wdata = lnk_rdata;
				state_d   = sllm_pkg::S_IN_HOOK;
			end
			sllm_pkg::S_IN_HOOK: begin
				lnk_we    = 1'b1;
				lnk_waddr = p_q;
				lnk_wdata = q_q;
				status_d  = sllm_pkg::ST_OK;
				state_d   = sllm_pkg::S_FINISH;
			end
			sllm_pkg::S_DL_NEXT: begin
				q_d = lnk_rdata;
				if (lnk_rdata == '0) begin
					state_d = sllm_pkg::S_FINISH;
				end else begin
					lnk_raddr = lnk_rdata;
					dat_raddr = lnk_rdata;
					state_d   = sllm_pkg::S_DL_UNLK;
				end
			end
			sllm_pkg::S_DL_UNLK: begin
				rval_d    = dat_rdata;
				lnk_we    = 1'b1;
				lnk_waddr = p_q;
				lnk_wdata = lnk_rdata;
				state_d   = sllm_pkg::S_DL_GIVE;
			end
			sllm_pkg::S_DL_GIVE: begin
				lnk_we    = 1'b1;
				lnk_waddr = q_q;
				lnk_wdata = fh_q;
				fh_d      = q_q;
				status_d  = sllm_pkg::ST_OK;
				state_d   = sllm_pkg::S_FINISH;
			end
			sllm_pkg::S_GT_DATA: begin
				rval_d   = dat_rdata;
				status_d = sllm_pkg::ST_OK;
				state_d  = sllm_pkg::S_FINISH;
			end
			sllm_pkg::S_SC_HEAD: begin
				p_d     = lnk_rdata;
				state_d = sllm_pkg::S_SC_CHK;
			end
			sllm_pkg::S_SC_CHK: begin
				if (p_q != '0 && guard_live) begin
					lnk_raddr = p_q;
					dat_raddr = p_q;
					state_d   = sllm_pkg::S_SC_STEP;
				end else begin
					if (act_q == sllm_pkg::ACT_LENGTH) begin
						rcount_d = sllm_pkg::COUNT_W'(guard_q);
						status_d = sllm_pkg::ST_OK;
					end
					state_d = sllm_pkg::S_FINISH;
				end
			end
			sllm_pkg::S_SC_STEP: begin
				guard_d = guard_inc;
				if (act_q == sllm_pkg::ACT_LOCATE && dat_rdata == val_q) begin
					rcount_d = sllm_pkg::COUNT_W'(guard_inc);
					status_d = sllm_pkg::ST_OK;
					state_d  = sllm_pkg::S_FINISH;
				end else begin
					p_d     = lnk_rdata;
					state_d = sllm_pkg::S_SC_CHK;
				end
			end
			sllm_pkg::S_FINISH: begin
				if (taken) begin
					state_d = sllm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sllm_pkg::S_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/static_linked_list_manager.sv
// Top level of the static linked list manager: request/result handshakes,
// result register, link and data stores. Depends on sllm_pkg, sllm_mem, sllm_seq.
//
// Usage:
//   Requests arrive as beats on the input channel (in_valid/in_ready) carrying
//   action, list_handle, position and item_value. Each request yields exactly
//   one result beat on the output channel (out_valid/out_ready) carrying
//   status, result_value, result_count and new_handle.
//   One request is in work at a time; in_ready is high only while the
//   sequencer is idle. Every step goes through the one read port of the link
//   store, and each link followed is first read, then used. A result register
//   parts the two channels, so the next request is taken while a result still
//   waits.
//   After reset the block lays the free chain into the link store, one node a
//   cycle; in_ready stays low until that pass is done.
//   When the receiver stalls, hold the result beat; the sequencer finishes
//   the next request and then waits with it until the result register frees.
`timescale 1ns / 1ps

module static_linked_list_manager #(
	parameter int unsigned POOL_NODES = 64,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [5:0]  list_handle,
	input  logic [5:0]  position,
	input  logic [31:0] item_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] result_value,
	output logic [5:0]  result_count,
	output logic [5:0]  new_handle
);

	localparam int unsigned AW = $clog2(POOL_NODES);

	sllm_pkg::req_t req;
	sllm_pkg::res_t seq_res;
	sllm_pkg::res_t res_q;

	logic          seq_idle;
	logic          seq_done;
	logic          res_taken;
	logic          out_valid_q;

	logic          lnk_we;
	logic [AW-1:0] lnk_waddr;
	logic [AW-1:0] lnk_wdata;
	logic [AW-1:0] lnk_raddr;
	logic [AW-1:0] lnk_rdata;

	logic                  dat_we;
	logic [AW-1:0]         dat_waddr;
	logic [DATA_WIDTH-1:0] dat_wdata;
	logic [AW-1:0]         dat_raddr;
	logic [DATA_WIDTH-1:0] dat_rdata;

	// gather the request beat
	always_comb begin
		req.action      = sllm_pkg::action_t'(action);
		req.list_handle = list_handle;
		req.position    = position;
		req.item_value  = item_value;
	end

	assign in_ready = seq_idle;

	// the result register is free when empty or being drained this cycle
	assign res_taken = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_done && res_taken) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result payload while the receiver stalls
	always_ff @(posedge clk) begin
		if (seq_done && res_taken) begin
			res_q <= seq_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = res_q.status;
	assign result_value = res_q.result_value;
	assign result_count = res_q.result_count;
	assign new_handle   = res_q.new_handle;

	sllm_seq #(
		.POOL_NODES (POOL_NODES),
		.DATA_WIDTH (DATA_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid),
		.req       (req),
		.idle      (seq_idle),
		.done      (seq_done),
		.taken     (res_taken),
		.res       (seq_res),
		.lnk_we    (lnk_we),
		.lnk_waddr (lnk_waddr),
		.lnk_wdata (lnk_wdata),
		.lnk_raddr (lnk_raddr),
		.lnk_rdata (lnk_rdata),
		.dat_we    (dat_we),
		.dat_waddr (dat_waddr),
		.dat_wdata (dat_wdata),
		.dat_raddr (dat_raddr),
		.dat_rdata (dat_rdata)
	);

	// link store: next-node index per pool node
	sllm_mem #(
		.WIDTH (AW),
		.DEPTH (POOL_NODES)
	) u_link_store (
		.clk   (clk),
		.we    (lnk_we),
		.waddr (lnk_waddr),
		.wdata (lnk_wdata),
		.raddr (lnk_raddr),
		.rdata (lnk_rdata)
	);

	// data store: element value per pool node
	sllm_mem #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (POOL_NODES)
	) u_data_store (
		.clk   (clk),
		.we    (dat_we),
		.waddr (dat_waddr),
		.wdata (dat_wdata),
		.raddr (dat_raddr),
		.rdata (dat_rdata)
	);

endmodule
